### src/rpj_pkg.sv
// shared constants, types and rounding helpers for the reprojection jacobian block
// no dependencies; imported by every module of the block

package rpj_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int JAC_WIDTH       = 48;
   localparam int JAC_FRAC        = 24;
   localparam int ROT_FRAC        = 30;

   localparam int COORD_W = 32;
   localparam int FOCAL_W = 32;
   localparam int R_W     = 36;
   localparam int QP_W    = 2 * COORD_W;
   localparam int RP_W    = R_W + COORD_W;
   localparam int BFP_W   = R_W + FOCAL_W + 1;
   localparam int FP_W    = COORD_W + FOCAL_W + 1;

   localparam int A_W     = 72 + JAC_FRAC - COORD_FRAC_BITS;
   localparam int A_LO_W  = A_W / 2;
   localparam int A_HI_W  = A_W - A_LO_W;
   localparam int PL_W    = A_LO_W + FOCAL_W;
   localparam int PH_W    = A_HI_W + FOCAL_W + 1;
   localparam int NUM_W   = A_W + FOCAL_W + 2;
   localparam int DEN_W   = 2 * COORD_W + ROT_FRAC - JAC_FRAC;
   localparam int DIV_W   = (NUM_W > DEN_W + JAC_WIDTH) ? NUM_W : DEN_W + JAC_WIDTH;
   localparam int DIV_LAT = JAC_WIDTH + 2;
   localparam int NLANES  = 8;

   localparam int REQ_DATA_W = 10 * COORD_W;
   localparam int RSP_DATA_W = ((9 * JAC_WIDTH + 7) / 8) * 8;

   localparam logic [FOCAL_W-1:0] FOCAL_RESET = 32'd32768000;

   localparam logic [1:0] CSR_FOCAL_X    = 2'd0;
   localparam logic [1:0] CSR_FOCAL_Y    = 2'd1;
   localparam logic [1:0] CSR_FOCAL_BASE = 2'd2;

   localparam logic [1:0] ROW_U = 2'd0;
   localparam logic [1:0] ROW_V = 2'd1;
   localparam logic [1:0] ROW_R = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec3_type;

   typedef struct packed {
      logic                      mode;
      logic signed [COORD_W-1:0] qw;
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qy;
      logic signed [COORD_W-1:0] qz;
      vec3_type                  trans;
      vec3_type                  point;
   } item_type;

   typedef struct packed {
      logic [1:0] row;
      logic       last;
   } tag_type;

   typedef struct packed {
      logic [FOCAL_W-1:0] fx;
      logic [FOCAL_W-1:0] fy;
      logic [FOCAL_W-1:0] bf;
   } focal_type;

   // round to nearest, ties away from zero, then arithmetic shift right
   function automatic logic signed [127:0] round_shift(input logic signed [127:0] v,
                                                       input int unsigned sh);
      logic [127:0] mag;
      logic [127:0] rnd;
      mag = v[127] ? $unsigned(-v) : $unsigned(v);
      rnd = (mag + (128'd1 << (sh - 1))) >> sh;
      return v[127] ? -$signed(rnd) : $signed(rnd);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [127:0] v);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (COORD_W - 1)) - 128'sd1;
      lo = -(128'sd1 <<< (COORD_W - 1));
      if (v > hi) return hi[COORD_W-1:0];
      if (v < lo) return lo[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

endpackage

### src/rpj_rot.sv
// quaternion to rotation matrix and world to camera transform, four stages
// depends on rpj_pkg

module rpj_rot (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rpj_pkg::tag_type              in_tag,
   input  rpj_pkg::item_type             in_item,
   output logic                          out_valid,
   output rpj_pkg::tag_type              out_tag,
   output logic                          out_bad,
   output rpj_pkg::vec3_type             out_cam,
   output logic [8:0][rpj_pkg::R_W-1:0]  out_rot
);
   import rpj_pkg::*;

   localparam int PXX = 0, PYY = 1, PZZ = 2, PXY = 3, PZW = 4;
   localparam int PXZ = 5, PYW = 6, PYZ = 7, PXW = 8;

   // stage 1: quaternion products
   logic                     s1_valid_ff;
   tag_type                  s1_tag_ff;
   vec3_type                 s1_trans_ff, s1_point_ff;
   logic signed [QP_W-1:0]   s1_prod_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff        <= in_tag;
         s1_trans_ff      <= in_item.trans;
         s1_point_ff      <= in_item.point;
         s1_prod_ff[PXX]  <= in_item.qx * in_item.qx;
         s1_prod_ff[PYY]  <= in_item.qy * in_item.qy;
         s1_prod_ff[PZZ]  <= in_item.qz * in_item.qz;
         s1_prod_ff[PXY]  <= in_item.qx * in_item.qy;
         s1_prod_ff[PZW]  <= in_item.qz * in_item.qw;
         s1_prod_ff[PXZ]  <= in_item.qx * in_item.qz;
         s1_prod_ff[PYW]  <= in_item.qy * in_item.qw;
         s1_prod_ff[PYZ]  <= in_item.qy * in_item.qz;
         s1_prod_ff[PXW]  <= in_item.qx * in_item.qw;
      end
   end

   // stage 2: matrix entries rounded to q30
   logic                   s2_valid_ff;
   tag_type                s2_tag_ff;
   vec3_type               s2_trans_ff, s2_point_ff;
   logic [8:0][R_W-1:0]    s2_rot_ff, s2_rot_in;

   always_comb begin
      logic signed [127:0] p [9];
      logic signed [127:0] one;
      logic signed [127:0] raw [9];
      logic signed [127:0] rnd;
      one = 128'sd1 <<< (2 * ROT_FRAC);
      for (int i = 0; i < 9; i++) p[i] = s1_prod_ff[i];
      raw[0] = one - ((p[PYY] + p[PZZ]) <<< 1);
      raw[4] = one - ((p[PXX] + p[PZZ]) <<< 1);
      raw[8] = one - ((p[PXX] + p[PYY]) <<< 1);
      raw[1] = (p[PXY] - p[PZW]) <<< 1;
      raw[3] = (p[PXY] + p[PZW]) <<< 1;
      raw[2] = (p[PXZ] + p[PYW]) <<< 1;
      raw[6] = (p[PXZ] - p[PYW]) <<< 1;
      raw[5] = (p[PYZ] - p[PXW]) <<< 1;
      raw[7] = (p[PYZ] + p[PXW]) <<< 1;
      for (int i = 0; i < 9; i++) begin
         rnd = round_shift(raw[i], ROT_FRAC);
         s2_rot_in[i] = rnd[R_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_tag_ff   <= s1_tag_ff;
         s2_trans_ff <= s1_trans_ff;
         s2_point_ff <= s1_point_ff;
         s2_rot_ff   <= s2_rot_in;
      end
   end

   // stage 3: matrix times point products
   logic                   s3_valid_ff;
   tag_type                s3_tag_ff;
   vec3_type               s3_trans_ff;
   logic [8:0][R_W-1:0]    s3_rot_ff;
   logic signed [RP_W-1:0] s3_prod_ff [9];
   logic signed [COORD_W-1:0] pnt [3];

   assign pnt[0] = s2_point_ff.x;
   assign pnt[1] = s2_point_ff.y;
   assign pnt[2] = s2_point_ff.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_tag_ff   <= s2_tag_ff;
         s3_trans_ff <= s2_trans_ff;
         s3_rot_ff   <= s2_rot_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               s3_prod_ff[i*3+j] <= $signed(s2_rot_ff[i*3+j]) * pnt[j];
            end
         end
      end
   end

   // stage 4: add translation, round to coordinate format
   logic                   s4_valid_ff;
   tag_type                s4_tag_ff;
   logic                   s4_bad_ff;
   vec3_type               s4_cam_ff, s4_cam_in;
   logic [8:0][R_W-1:0]    s4_rot_ff;

   always_comb begin
      logic signed [127:0] tr [3];
      logic signed [127:0] acc [3];
      tr[0] = s3_trans_ff.x;
      tr[1] = s3_trans_ff.y;
      tr[2] = s3_trans_ff.z;
      for (int i = 0; i < 3; i++) begin
         acc[i] = (tr[i] <<< ROT_FRAC) + 128'(s3_prod_ff[i*3]) + 128'(s3_prod_ff[i*3+1])
                + 128'(s3_prod_ff[i*3+2]);
      end
      s4_cam_in.x = sat_coord(round_shift(acc[0], ROT_FRAC));
      s4_cam_in.y = sat_coord(round_shift(acc[1], ROT_FRAC));
      s4_cam_in.z = sat_coord(round_shift(acc[2], ROT_FRAC));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_tag_ff <= s3_tag_ff;
         s4_cam_ff <= s4_cam_in;
         s4_bad_ff <= (s4_cam_in.z <= 0);
         s4_rot_ff <= s3_rot_ff;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_tag   = s4_tag_ff;
   assign out_bad   = s4_bad_ff;
   assign out_cam   = s4_cam_ff;
   assign out_rot   = s4_rot_ff;

endmodule

### src/rpj_num.sv
// jacobian numerators and denominators for one row, eight lanes, four stages
// depends on rpj_pkg

module rpj_num (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  rpj_pkg::tag_type                   in_tag,
   input  logic                               in_bad,
   input  rpj_pkg::vec3_type                  in_cam,
   input  logic [8:0][rpj_pkg::R_W-1:0]       in_rot,
   input  rpj_pkg::focal_type                 focal,
   output logic                               out_valid,
   output rpj_pkg::tag_type                   out_tag,
   output logic                               out_bad,
   output logic signed [rpj_pkg::NUM_W-1:0]   out_num [rpj_pkg::NLANES],
   output logic [rpj_pkg::DEN_W-1:0]          out_den [rpj_pkg::NLANES]
);
   import rpj_pkg::*;

   localparam int JF = JAC_FRAC - COORD_FRAC_BITS;

   // stage 5: first layer of products
   logic                    s5_valid_ff, s5_bad_ff;
   tag_type                 s5_tag_ff;
   vec3_type                s5_cam_ff;
   logic signed [QP_W-1:0]  s5_zz_ff, s5_xx_ff, s5_yy_ff, s5_xy_ff;
   logic signed [RP_W-1:0]  s5_xr2_ff [3], s5_zr0_ff [3], s5_yr2_ff [3], s5_zr1_ff [3];
   logic signed [BFP_W-1:0] s5_r2bf_ff [3];
   logic signed [FP_W-1:0]  s5_xbf_ff, s5_ybf_ff;
   logic signed [FOCAL_W:0] bf_s;

   assign bf_s = $signed({1'b0, focal.bf});

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_tag_ff <= in_tag;
         s5_bad_ff <= in_bad;
         s5_cam_ff <= in_cam;
         s5_zz_ff  <= in_cam.z * in_cam.z;
         s5_xx_ff  <= in_cam.x * in_cam.x;
         s5_yy_ff  <= in_cam.y * in_cam.y;
         s5_xy_ff  <= in_cam.x * in_cam.y;
         s5_xbf_ff <= in_cam.x * bf_s;
         s5_ybf_ff <= in_cam.y * bf_s;
         for (int j = 0; j < 3; j++) begin
            s5_xr2_ff[j]  <= in_cam.x * $signed(in_rot[6+j]);
            s5_zr0_ff[j]  <= in_cam.z * $signed(in_rot[j]);
            s5_yr2_ff[j]  <= in_cam.y * $signed(in_rot[6+j]);
            s5_zr1_ff[j]  <= in_cam.z * $signed(in_rot[3+j]);
            s5_r2bf_ff[j] <= $signed(in_rot[6+j]) * bf_s;
         end
      end
   end

   // stage 6: per row selection of factor, focal multiplier, addend and divisor
   logic                    s6_valid_ff, s6_bad_ff;
   tag_type                 s6_tag_ff;
   logic signed [A_W-1:0]   s6_a_ff [NLANES], s6_a_in [NLANES];
   logic [FOCAL_W-1:0]      s6_b_ff, s6_b_in;
   logic signed [NUM_W-1:0] s6_c_ff [NLANES], s6_c_in [NLANES];
   logic [DEN_W-1:0]        s6_den_ff [NLANES], s6_den_in [NLANES];

   always_comb begin
      logic signed [127:0] du [3], dv [3], sr [3];
      logic signed [127:0] zz, xy8, xx1, yy1, x8, y8, x24, y24, m24, cy, cx, cb;
      logic signed [127:0] a [NLANES];
      logic signed [127:0] c [NLANES];
      logic [DEN_W-1:0]    dz, dzz, ddp;
      zz  = s5_zz_ff;
      xy8 = 128'(s5_xy_ff) <<< JF;
      xx1 = (zz + 128'(s5_xx_ff)) <<< JF;
      yy1 = (zz + 128'(s5_yy_ff)) <<< JF;
      x8  = 128'(s5_cam_ff.x) <<< JF;
      y8  = 128'(s5_cam_ff.y) <<< JF;
      x24 = 128'(s5_cam_ff.x) <<< JAC_FRAC;
      y24 = 128'(s5_cam_ff.y) <<< JAC_FRAC;
      m24 = -(128'sd1 <<< JAC_FRAC);
      cy  = -(128'(s5_ybf_ff) <<< JAC_FRAC);
      cx  = 128'(s5_xbf_ff) <<< JAC_FRAC;
      cb  = -($signed({96'd0, focal.bf}) <<< (COORD_FRAC_BITS + JAC_FRAC));
      for (int j = 0; j < 3; j++) begin
         du[j] = 128'(s5_xr2_ff[j]) - 128'(s5_zr0_ff[j]);
         dv[j] = 128'(s5_yr2_ff[j]) - 128'(s5_zr1_ff[j]);
         sr[j] = -(128'(s5_r2bf_ff[j]) <<< COORD_FRAC_BITS);
      end
      dz  = DEN_W'(s5_cam_ff.z[COORD_W-1:0]);
      dzz = DEN_W'(s5_zz_ff[QP_W-1:0]);
      ddp = dzz << (ROT_FRAC - JAC_FRAC);
      for (int k = 0; k < NLANES; k++) c[k] = '0;
      case (s5_tag_ff.row)
         ROW_V: begin
            s6_b_in = focal.fy;
            for (int j = 0; j < 3; j++) a[j] = dv[j];
            a[3] = yy1;
            a[4] = -xy8;
            a[5] = -x8;
            a[6] = m24;
            a[7] = y24;
         end
         ROW_U: begin
            s6_b_in = focal.fx;
            for (int j = 0; j < 3; j++) a[j] = du[j];
            a[3] = xy8;
            a[4] = -xx1;
            a[5] = y8;
            a[6] = m24;
            a[7] = x24;
         end
         default: begin
            // right image row: row u terms plus the baseline terms
            s6_b_in = focal.fx;
            for (int j = 0; j < 3; j++) begin
               a[j] = du[j];
               c[j] = sr[j];
            end
            a[3] = xy8;
            a[4] = -xx1;
            a[5] = y8;
            a[6] = m24;
            a[7] = x24;
            c[3] = cy;
            c[4] = cx;
            c[7] = cb;
         end
      endcase
      for (int k = 0; k < NLANES; k++) begin
         s6_a_in[k] = a[k][A_W-1:0];
         s6_c_in[k] = c[k][NUM_W-1:0];
      end
      for (int j = 0; j < 3; j++) s6_den_in[j] = ddp;
      s6_den_in[3] = dzz;
      s6_den_in[4] = dzz;
      s6_den_in[5] = dz;
      s6_den_in[6] = dz;
      s6_den_in[7] = dzz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_tag_ff <= s5_tag_ff;
         s6_bad_ff <= s5_bad_ff;
         s6_b_ff   <= s6_b_in;
         s6_a_ff   <= s6_a_in;
         s6_c_ff   <= s6_c_in;
         s6_den_ff <= s6_den_in;
      end
   end

   // stage 7: focal products split in two halves
   logic                    s7_valid_ff, s7_bad_ff;
   tag_type                 s7_tag_ff;
   logic [PL_W-1:0]         s7_pl_ff [NLANES];
   logic signed [PH_W-1:0]  s7_ph_ff [NLANES];
   logic signed [NUM_W-1:0] s7_c_ff [NLANES];
   logic [DEN_W-1:0]        s7_den_ff [NLANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_tag_ff <= s6_tag_ff;
         s7_bad_ff <= s6_bad_ff;
         s7_c_ff   <= s6_c_ff;
         s7_den_ff <= s6_den_ff;
         for (int k = 0; k < NLANES; k++) begin
            s7_pl_ff[k] <= PL_W'(s6_a_ff[k][A_LO_W-1:0]) * PL_W'(s6_b_ff);
            s7_ph_ff[k] <= $signed(s6_a_ff[k][A_W-1:A_LO_W]) * $signed({1'b0, s6_b_ff});
         end
      end
   end

   // stage 8: recombine halves and addend
   logic                    s8_valid_ff, s8_bad_ff;
   tag_type                 s8_tag_ff;
   logic signed [NUM_W-1:0] s8_num_ff [NLANES], s8_num_in [NLANES];
   logic [DEN_W-1:0]        s8_den_ff [NLANES];

   always_comb begin
      logic signed [127:0] sum;
      for (int k = 0; k < NLANES; k++) begin
         sum = (128'(s7_ph_ff[k]) <<< A_LO_W) + $signed({{(128-PL_W){1'b0}}, s7_pl_ff[k]})
             + 128'(s7_c_ff[k]);
         s8_num_in[k] = sum[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_tag_ff <= s7_tag_ff;
         s8_bad_ff <= s7_bad_ff;
         s8_num_ff <= s8_num_in;
         s8_den_ff <= s7_den_ff;
      end
   end

   assign out_valid = s8_valid_ff;
   assign out_tag   = s8_tag_ff;
   assign out_bad   = s8_bad_ff;
   assign out_num   = s8_num_ff;
   assign out_den   = s8_den_ff;

endmodule

### src/rpj_div.sv
// pipelined restoring divider, one quotient bit a stage, rounded and saturated
// depends on rpj_pkg

module rpj_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [rpj_pkg::NUM_W-1:0]  num,
   input  logic [rpj_pkg::DEN_W-1:0]         den,
   output logic [rpj_pkg::JAC_WIDTH-1:0]     quo
);
   import rpj_pkg::*;

   localparam int W = JAC_WIDTH;

   logic [DIV_W-1:0] rem_ff [W+1];
   logic [W-1:0]     quo_ff [W+1];
   logic [DEN_W-1:0] den_ff [W+1];
   logic             neg_ff [W+1];
   logic             ovf_ff [W+1];
   logic [W-1:0]     out_ff, out_in;

   // entry stage: magnitude and overflow check against den * 2^W
   logic [NUM_W-1:0] mag;
   assign mag = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DIV_W'(mag);
         quo_ff[0] <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= num[NUM_W-1];
         ovf_ff[0] <= DIV_W'(mag) >= (DIV_W'(den) << W);
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_step
      logic [DIV_W-1:0] trial;
      logic             fits;
      logic [DIV_W-1:0] rem_in;
      logic [W-1:0]     quo_in;

      always_comb begin
         trial  = DIV_W'(den_ff[k]) << (W - 1 - k);
         fits   = rem_ff[k] >= trial;
         rem_in = fits ? rem_ff[k] - trial : rem_ff[k];
         quo_in = fits ? (quo_ff[k] | (W'(1) << (W - 1 - k))) : quo_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            quo_ff[k+1] <= quo_in;
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   // rounding half away from zero, then saturation to the signed width
   always_comb begin
      logic         up;
      logic [W:0]   q1;
      logic [W:0]   lim;
      up  = {rem_ff[W][DEN_W-1:0], 1'b0} >= {1'b0, den_ff[W]};
      q1  = {1'b0, quo_ff[W]} + (W+1)'(up);
      lim = (W+1)'(1) << (W - 1);
      if (neg_ff[W]) begin
         if (ovf_ff[W] || q1 > lim) out_in = lim[W-1:0];
         else                       out_in = W'(-q1);
      end else begin
         if (ovf_ff[W] || q1 >= lim) out_in = W'(lim - 1'b1);
         else                        out_in = q1[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign quo = out_ff;

endmodule

### src/reprojection_jacobian.sv
// top level of the pinhole reprojection jacobian block
// depends on rpj_pkg, rpj_rot, rpj_num and rpj_div
//
//   channel | direction | handshake          | contents
//   req     | in        | tvalid/tready      | tdata pose and point, tuser mode
//   rsp     | out       | tvalid/tready      | tdata jacobian row, tuser row and flag, tlast
//   csr     | in        | csr_valid/ready    | csr_index, csr_data focal registers
//
// one row enters the pipeline per cycle from the row issue stage while rsp is not
// held, two rows per request in mono mode and three in stereo mode
// from issue a row passes the rotation stages, the numerator stages, the divider
// lanes (one quotient bit a stage) and the output register before rsp_tvalid
// reset clears all valid bits and loads the focal registers with 500.0, 500.0, 0
// held rsp freezes pipeline and row issue; an empty issue stage still accepts a request

module reprojection_jacobian (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z, point_x, point_y, point_z
   input  logic [rpj_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // point_jac_0..2, pose_jac_0..5
   output logic [rpj_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // row_index[1:0], depth_invalid
   output logic [2:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [rpj_pkg::FOCAL_W-1:0]      csr_data
);
   import rpj_pkg::*;

   // focal registers
   focal_type focal_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff.fx <= FOCAL_RESET;
         focal_ff.fy <= FOCAL_RESET;
         focal_ff.bf <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FOCAL_X:    focal_ff.fx <= csr_data;
            CSR_FOCAL_Y:    focal_ff.fy <= csr_data;
            CSR_FOCAL_BASE: focal_ff.bf <= csr_data;
            default:        ;
         endcase
      end
   end

   // pipeline advances whenever the output register is free or being taken
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_tready;

   // row issue stage: holds one request and hands out its rows
   item_type   hold_ff;
   logic       hold_valid_ff, hold_valid_in;
   logic [1:0] row_ff, row_in;
   logic       last_issue;
   logic       req_accept;
   tag_type    issue_tag;

   assign last_issue = row_ff == (hold_ff.mode ? ROW_R : ROW_V);
   assign req_tready = !hold_valid_ff || (en && last_issue);
   assign req_accept = req_tvalid && req_tready;
   assign issue_tag  = '{row: row_ff, last: last_issue};

   always_comb begin
      hold_valid_in = hold_valid_ff;
      row_in        = row_ff;
      if (en && hold_valid_ff) begin
         if (last_issue) hold_valid_in = 1'b0;
         else            row_in = row_ff + 2'd1;
      end
      if (req_accept) begin
         hold_valid_in = 1'b1;
         row_in        = ROW_U;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         row_ff        <= ROW_U;
      end else begin
         hold_valid_ff <= hold_valid_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_ff.mode    <= req_tuser[0];
         hold_ff.qw      <= req_tdata[0*COORD_W +: COORD_W];
         hold_ff.qx      <= req_tdata[1*COORD_W +: COORD_W];
         hold_ff.qy      <= req_tdata[2*COORD_W +: COORD_W];
         hold_ff.qz      <= req_tdata[3*COORD_W +: COORD_W];
         hold_ff.trans.x <= req_tdata[4*COORD_W +: COORD_W];
         hold_ff.trans.y <= req_tdata[5*COORD_W +: COORD_W];
         hold_ff.trans.z <= req_tdata[6*COORD_W +: COORD_W];
         hold_ff.point.x <= req_tdata[7*COORD_W +: COORD_W];
         hold_ff.point.y <= req_tdata[8*COORD_W +: COORD_W];
         hold_ff.point.z <= req_tdata[9*COORD_W +: COORD_W];
      end
   end

   // rotation and camera coordinates
   logic                rot_valid, rot_bad;
   tag_type             rot_tag;
   vec3_type            rot_cam;
   logic [8:0][R_W-1:0] rot_mat;

   rpj_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (hold_valid_ff),
      .in_tag    (issue_tag),
      .in_item   (hold_ff),
      .out_valid (rot_valid),
      .out_tag   (rot_tag),
      .out_bad   (rot_bad),
      .out_cam   (rot_cam),
      .out_rot   (rot_mat)
   );

   // numerators and divisors of the selected row
   logic                    num_valid, num_bad;
   tag_type                 num_tag;
   logic signed [NUM_W-1:0] num_val [NLANES];
   logic [DEN_W-1:0]        num_den [NLANES];

   rpj_num u_num (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rot_valid),
      .in_tag    (rot_tag),
      .in_bad    (rot_bad),
      .in_cam    (rot_cam),
      .in_rot    (rot_mat),
      .focal     (focal_ff),
      .out_valid (num_valid),
      .out_tag   (num_tag),
      .out_bad   (num_bad),
      .out_num   (num_val),
      .out_den   (num_den)
   );

   // eight divider lanes, one per nonconstant jacobian entry
   logic [JAC_WIDTH-1:0] lane_q [NLANES];

   for (genvar k = 0; k < NLANES; k++) begin : g_lane
      rpj_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num_val[k]),
         .den   (num_den[k]),
         .quo   (lane_q[k])
      );
   end

   // row tag and flag travel beside the divider lanes
   logic    side_valid_ff [DIV_LAT];
   tag_type side_tag_ff [DIV_LAT];
   logic    side_bad_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) side_valid_ff[k] <= 1'b0;
      end else if (en) begin
         side_valid_ff[0] <= num_valid;
         for (int k = 1; k < DIV_LAT; k++) side_valid_ff[k] <= side_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_tag_ff[0] <= num_tag;
         side_bad_ff[0] <= num_bad;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_tag_ff[k] <= side_tag_ff[k-1];
            side_bad_ff[k] <= side_bad_ff[k-1];
         end
      end
   end

   // output register: place lanes into the row, zero everything on bad depth
   tag_type                rsp_tag_ff;
   logic                   rsp_bad_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   always_comb begin
      logic [JAC_WIDTH-1:0] ent [9];
      tag_type              t;
      t = side_tag_ff[DIV_LAT-1];
      for (int k = 0; k < 9; k++) ent[k] = '0;
      for (int j = 0; j < 3; j++) ent[j] = lane_q[j];
      ent[3] = lane_q[3];
      ent[4] = lane_q[4];
      ent[5] = lane_q[5];
      // translation lane lands on x for rows u and right u, on y for row v
      if (t.row == ROW_V) ent[7] = lane_q[6];
      else                ent[6] = lane_q[6];
      ent[8] = lane_q[7];
      rsp_data_in = '0;
      if (!side_bad_ff[DIV_LAT-1]) begin
         for (int k = 0; k < 9; k++) rsp_data_in[k*JAC_WIDTH +: JAC_WIDTH] = ent[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tag_ff  <= side_tag_ff[DIV_LAT-1];
         rsp_bad_ff  <= side_bad_ff[DIV_LAT-1];
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_tag_ff.row};
   assign rsp_tlast  = rsp_tag_ff.last;

endmodule

### tb/reprojection_jacobian_tb.sv
// testbench for the pinhole reprojection jacobian block: random and directed requests,
// a bit exact predictor of every jacobian row and a scoreboard that checks each row
// depends on rpj_pkg and reprojection_jacobian
`timescale 1ns / 100ps

module reprojection_jacobian_tb;
   import rpj_pkg::*;

   typedef logic signed [255:0] wide_type;

   // one request: mode plus ten 32 bit fields in tdata order
   typedef struct {
      logic              mode;
      logic signed [31:0] f [10];
   } pose_req_type;

   // one expected jacobian row
   typedef struct {
      logic [1:0]            row;
      logic                  last;
      logic                  bad;
      logic [RSP_DATA_W-1:0] jac;
   } jac_row_type;

   class jacobian_scoreboard;
      jac_row_type rows_due [$];
      logic [31:0] fx, fy, bf;
      int          errors;

      function new();
         fx = FOCAL_RESET;
         fy = FOCAL_RESET;
         bf = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         if (idx == CSR_FOCAL_X) fx = val;
         else if (idx == CSR_FOCAL_Y) fy = val;
         else if (idx == CSR_FOCAL_BASE) bf = val;
      endfunction

      // num/den rounded to nearest, ties away from zero, saturated to bits signed
      function wide_type round_div(wide_type num, wide_type den, int bits);
         wide_type mag, q, r, lim, one;
         logic     neg;
         one = 1;
         neg = num < 0;
         mag = neg ? -num : num;
         q = mag / den;
         r = mag % den;
         if (r >= den - r) q = q + 1;
         lim = one <<< (bits - 1);
         if (neg) begin
            if (q > lim) q = lim;
            q = -q;
         end else if (q > lim - 1) begin
            q = lim - 1;
         end
         return q;
      endfunction

      function wide_type rot_diag(wide_type a, wide_type b);
         wide_type one;
         one = 1;
         return round_div((one <<< 60) - ((a * a + b * b) <<< 1), one <<< ROT_FRAC, 40);
      endfunction

      function wide_type rot_off(wide_type a, wide_type b, wide_type c, wide_type d,
                                 logic plus);
         wide_type one;
         one = 1;
         return round_div((plus ? (a * b + c * d) : (a * b - c * d)) <<< 1,
                          one <<< ROT_FRAC, 40);
      endfunction

      // work out the rows caused by one accepted request
      function void note_request(pose_req_type it);
         wide_type    qw, qx, qy, qz, one, FX, FY, BF, X, Y, Z, zz, dpt, xy, xx1, yy1;
         wide_type    a0, b0, e0, u, v, s, acc;
         wide_type    t [3], p [3], c [3], R [3][3], pj [3][3], po [3][6];
         logic        bad;
         int          nrows;
         jac_row_type e;
         one = 1;
         qw = it.f[0]; qx = it.f[1]; qy = it.f[2]; qz = it.f[3];
         for (int i = 0; i < 3; i++) begin
            t[i] = it.f[4 + i];
            p[i] = it.f[7 + i];
         end
         FX = wide_type'({224'd0, fx});
         FY = wide_type'({224'd0, fy});
         BF = wide_type'({224'd0, bf});
         R[0][0] = rot_diag(qy, qz); R[1][1] = rot_diag(qx, qz); R[2][2] = rot_diag(qx, qy);
         R[0][1] = rot_off(qx, qy, qz, qw, 0); R[1][0] = rot_off(qx, qy, qz, qw, 1);
         R[0][2] = rot_off(qx, qz, qy, qw, 1); R[2][0] = rot_off(qx, qz, qy, qw, 0);
         R[1][2] = rot_off(qy, qz, qx, qw, 0); R[2][1] = rot_off(qy, qz, qx, qw, 1);
         for (int i = 0; i < 3; i++) begin
            acc = t[i] <<< ROT_FRAC;
            for (int j = 0; j < 3; j++) acc = acc + R[i][j] * p[j];
            c[i] = round_div(acc, one <<< ROT_FRAC, 32);
         end
         bad = c[2] <= 0;
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) pj[k][j] = 0;
            for (int j = 0; j < 6; j++) po[k][j] = 0;
         end
         if (!bad) begin
            X = c[0]; Y = c[1]; Z = c[2];
            zz  = Z * Z;
            dpt = zz <<< (ROT_FRAC - JAC_FRAC);
            xy  = (X * Y) <<< 8;
            xx1 = (zz + X * X) <<< 8;
            yy1 = (zz + Y * Y) <<< 8;
            a0 = xy * FX;
            b0 = -(xx1 * FX);
            e0 = (X * FX) <<< JAC_FRAC;
            for (int j = 0; j < 3; j++) begin
               u = (X * R[2][j] - Z * R[0][j]) * FX;
               v = (Y * R[2][j] - Z * R[1][j]) * FY;
               s = (R[2][j] <<< COORD_FRAC_BITS) * BF;
               pj[0][j] = round_div(u, dpt, JAC_WIDTH);
               pj[1][j] = round_div(v, dpt, JAC_WIDTH);
               pj[2][j] = round_div(u - s, dpt, JAC_WIDTH);
            end
            po[0][0] = round_div(a0, zz, JAC_WIDTH);
            po[0][1] = round_div(b0, zz, JAC_WIDTH);
            po[0][2] = round_div((Y <<< 8) * FX, Z, JAC_WIDTH);
            po[0][3] = round_div(-(FX <<< JAC_FRAC), Z, JAC_WIDTH);
            po[0][5] = round_div(e0, zz, JAC_WIDTH);
            po[1][0] = round_div(yy1 * FY, zz, JAC_WIDTH);
            po[1][1] = round_div(-(xy * FY), zz, JAC_WIDTH);
            po[1][2] = round_div(-((X <<< 8) * FY), Z, JAC_WIDTH);
            po[1][4] = round_div(-(FY <<< JAC_FRAC), Z, JAC_WIDTH);
            po[1][5] = round_div((Y * FY) <<< JAC_FRAC, zz, JAC_WIDTH);
            po[2][0] = round_div(a0 - ((Y * BF) <<< JAC_FRAC), zz, JAC_WIDTH);
            po[2][1] = round_div(b0 + ((X * BF) <<< JAC_FRAC), zz, JAC_WIDTH);
            po[2][2] = po[0][2];
            po[2][3] = po[0][3];
            po[2][5] = round_div(e0 - (BF <<< (COORD_FRAC_BITS + JAC_FRAC)), zz, JAC_WIDTH);
         end
         nrows = it.mode ? 3 : 2;
         for (int k = 0; k < nrows; k++) begin
            e.row  = k[1:0];
            e.last = (k == nrows - 1);
            e.bad  = bad;
            e.jac  = '0;
            for (int j = 0; j < 3; j++) e.jac[JAC_WIDTH*j +: JAC_WIDTH] = pj[k][j][47:0];
            for (int j = 0; j < 6; j++) e.jac[JAC_WIDTH*(3+j) +: JAC_WIDTH] = po[k][j][47:0];
            rows_due.push_back(e);
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
         errors++;
      endtask

      task check_row(logic [RSP_DATA_W-1:0] data, logic [2:0] user, logic last);
         jac_row_type e;
         if (rows_due.size() == 0) begin
            report_mismatch("row with nothing expected", {61'd0, user}, 64'd0);
            return;
         end
         e = rows_due.pop_front();
         if (user[1:0] != e.row) report_mismatch("row_index", user[1:0], e.row);
         if (user[2] != e.bad) report_mismatch("depth_invalid", user[2], e.bad);
         if (last != e.last) report_mismatch("last_row", last, e.last);
         for (int j = 0; j < 9; j++) begin
            if (data[JAC_WIDTH*j +: JAC_WIDTH] != e.jac[JAC_WIDTH*j +: JAC_WIDTH])
               report_mismatch($sformatf("row %0d jacobian entry %0d", e.row, j),
                               data[JAC_WIDTH*j +: JAC_WIDTH], e.jac[JAC_WIDTH*j +: JAC_WIDTH]);
         end
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [31:0]           csr_data = '0;

   jacobian_scoreboard sb;
   bit                 no_idle = 0;   // set for stretches with back to back traffic
   int                 stall_left = 0;

   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
   localparam logic signed [31:0] FIX_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   always #6 clock = ~clock;

   reprojection_jacobian i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // mostly short gaps, now and then a long one
   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic pose_req_type mk(logic mode, logic signed [31:0] qw, qx, qy, qz,
                                       logic signed [31:0] tx, ty, tz, px, py, pz);
      pose_req_type it;
      it.mode = mode;
      it.f[0] = qw; it.f[1] = qx; it.f[2] = qy; it.f[3] = qz;
      it.f[4] = tx; it.f[5] = ty; it.f[6] = tz;
      it.f[7] = px; it.f[8] = py; it.f[9] = pz;
      return it;
   endfunction

   function automatic logic signed [31:0] rand_sym(logic [31:0] m);
      return $urandom_range(0, 2 * m) - m;
   endfunction

   // random quaternion component in Q2.30, from -1.0 to +1.0
   function automatic logic signed [31:0] rand_quat();
      return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
   endfunction

   function automatic pose_req_type make_random();
      pose_req_type it;
      int           kind;
      kind = $urandom_range(0, 9);
      it.mode = $urandom_range(0, 1);
      for (int i = 0; i < 4; i++) it.f[i] = rand_sym(32'h2000_0000);
      if (kind <= 5) begin
         // point in front of the camera: the usual case
         it.f[4] = rand_sym(32'h0010_0000);
         it.f[5] = rand_sym(32'h0010_0000);
         it.f[6] = $urandom_range(32'h0001_0000, 32'h0100_0000);
         for (int i = 7; i < 10; i++) it.f[i] = rand_sym(32'h0010_0000);
      end else if (kind <= 7) begin
         // raw noise, translation and point over the whole field range
         for (int i = 0; i < 4; i++) it.f[i] = rand_quat();
         for (int i = 4; i < 10; i++) it.f[i] = $urandom();
      end else if (kind == 8) begin
         // point behind the camera
         it.f[4] = rand_sym(32'h0010_0000);
         it.f[5] = rand_sym(32'h0010_0000);
         it.f[6] = -$signed($urandom_range(32'h0001_0000, 32'h0100_0000));
         for (int i = 7; i < 10; i++) it.f[i] = rand_sym(32'h0001_0000);
      end else begin
         // depth of a few lsb, pushes the jacobian into saturation
         it.f[0] = Q30_ONE; it.f[1] = 0; it.f[2] = 0; it.f[3] = 0;
         it.f[4] = rand_sym(32'h0100_0000);
         it.f[5] = rand_sym(32'h0100_0000);
         it.f[6] = $urandom_range(1, 16);
         for (int i = 7; i < 9; i++) it.f[i] = $urandom();
         it.f[9] = 0;
      end
      return it;
   endfunction

   task send_request(pose_req_type it);
      int gap;
      @(negedge clock);
      req_tvalid = 1;
      req_tuser  = it.mode;
      for (int i = 0; i < 10; i++) req_tdata[32*i +: 32] = it.f[i];
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
      gap = no_idle ? 0 : rand_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // drop valid after the last request of a burst
   task end_burst();
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task wait_drained();
      while (sb.rows_due.size() != 0) @(posedge clock);
   endtask

   // drained and past the pipeline latency, safe for register writes
   task wait_idle();
      end_burst();
      wait_drained();
      repeat (80) @(posedge clock);
   endtask

   task write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task set_focals(logic [31:0] fx, logic [31:0] fy, logic [31:0] bf);
      write_csr(CSR_FOCAL_X, fx);
      write_csr(CSR_FOCAL_Y, fy);
      write_csr(CSR_FOCAL_BASE, bf);
   endtask

   task send_random(int n);
      for (int i = 0; i < n; i++) send_request(make_random());
   endtask

   task send_directed();
      // identity pose, point straight ahead, mono then stereo
      send_request(mk(0, Q30_ONE, 0, 0, 0, 0, 0, 0, FIX_ONE, 2 * FIX_ONE, 5 * FIX_ONE));
      send_request(mk(1, Q30_ONE, 0, 0, 0, 0, 0, 0, -FIX_ONE, 3 * FIX_ONE, 7 * FIX_ONE));
      // depth exactly zero and negative
      send_request(mk(0, Q30_ONE, 0, 0, 0, 0, 0, 0, FIX_ONE, FIX_ONE, 0));
      send_request(mk(1, Q30_ONE, 0, 0, 0, 0, 0, 0, FIX_ONE, FIX_ONE, -3 * FIX_ONE));
      // quaternion extremes, unnormalized
      send_request(mk(1, -Q30_ONE, -Q30_ONE, -Q30_ONE, -Q30_ONE, 0, 0, 100 * FIX_ONE,
                      FIX_ONE, -FIX_ONE, FIX_ONE));
      send_request(mk(0, Q30_ONE, Q30_ONE, Q30_ONE, Q30_ONE, FIX_ONE, FIX_ONE,
                      50 * FIX_ONE, 2 * FIX_ONE, FIX_ONE, -FIX_ONE));
      send_request(mk(1, 0, 0, 0, 0, S32_MAX, S32_MAX, S32_MAX, 0, 0, 0));
      // coordinate saturation from both ends
      send_request(mk(1, Q30_ONE, 0, 0, 0, S32_MIN, S32_MIN, S32_MAX,
                      S32_MAX, S32_MAX, S32_MAX));
      send_request(mk(0, Q30_ONE, 0, 0, 0, S32_MIN, S32_MIN, S32_MIN,
                      S32_MIN, S32_MIN, S32_MIN));
      // depth of one lsb, jacobian saturates
      send_request(mk(1, Q30_ONE, 0, 0, 0, 0, 0, 0, S32_MAX, S32_MAX, 1));
      send_request(mk(0, Q30_ONE, 0, 0, 0, 0, 0, 0, S32_MIN, S32_MIN, 1));
      // quarter turn about x
      send_request(mk(1, 32'sd759250125, 32'sd759250125, 0, 0, 0, 0, 0,
                      FIX_ONE, 4 * FIX_ONE, FIX_ONE));
      send_request(mk(1, 0, 0, 0, Q30_ONE, 0, 0, 10 * FIX_ONE, 0, 0, 0));
      end_burst();
   endtask

   // receiver: stalls of random length, sampled at the rising edge
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_row(rsp_tdata, rsp_tuser, rsp_tlast);
         @(negedge clock);
         if (reset || no_idle) begin
            rsp_tready = !reset;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = rand_gap();
            rsp_tready = 0;
         end else begin
            rsp_tready = 1;
         end
      end
   end

   // hard limit on the run time
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset focal values
      send_directed();
      wait_idle();

      // random focal values, index three must be ignored
      set_focals($urandom_range(32'h0010_0000, 32'h1000_0000),
                 $urandom_range(32'h0010_0000, 32'h1000_0000), $urandom());
      write_csr(2'd3, $urandom());
      send_random(40);
      // hold off until the pipeline is empty, then carry on
      end_burst();
      wait_drained();
      send_random(40);
      wait_idle();

      // all ones / zero extremes
      set_focals(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
      send_directed();
      send_random(50);
      wait_idle();

      set_focals(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
      send_random(50);
      wait_idle();

      // back to back with no idling on either side
      set_focals($urandom(), $urandom(), $urandom());
      no_idle = 1;
      send_random(45);
      end_burst();
      wait_drained();
      no_idle = 0;
      repeat (80) @(posedge clock);

      if (sb.errors == 0 && sb.rows_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
